>>> hdl/fepd_pkg.sv
// shared types for the fax eol / rtc page detector
// request and response payload structs and the stop cause codes
// no dependencies
package fepd_pkg;

   // request kind carried in req_type
   localparam logic ITEM_DATA = 1'b0;
   localparam logic ITEM_TICK = 1'b1;

   typedef enum logic [1:0] {
      STOP_NONE       = 2'd0,
      STOP_DISCONNECT = 2'd1,
      STOP_CARRIER    = 2'd2
   } stop_cause_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic       carrier_present;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]    page_count;
      logic           eol_seen;
      logic           page_end;
      logic           stopped;
      stop_cause_type stop_cause;
   } rsp_payload_type;

endpackage

>>> hdl/fax_eol_rtc_page_detector.sv
// top level of the fax eol / rtc page detector
// scans received t.4 bytes for eol, rtc and the disconnect string, plus carrier timeout
// depends on fepd_pkg
//
// Every request transaction yields exactly one response transaction, which
// appears in the output register on the cycle after acceptance. The block
// takes one transaction per clock cycle: req_ready is high whenever the
// output register is empty or is being emptied in the same cycle, so the
// sustained rate is one item per cycle and is set only by the response
// handshake. Data bytes are scanned bit 0 first; a run of eleven or more
// zeros followed by a one bit is an end-of-line, six consecutive end-of-lines end a
// page and advance page_count (which starts at one and wraps). A byte stream
// spelling DISCONNECT, or carrier loss for more than timeout_ff
// ticks after the first carrier-less tick, stops the block until reset;
// later items still get a response repeating the page count and stop cause.
// The timeout register is written through the csr port (always ready, reset
// value 30) and should only be changed while the block is idle.
module fax_eol_rtc_page_detector #(
   parameter int TIMER_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fepd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output fepd_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [7:0]               csr_data
);

   localparam logic [3:0] EOL_MIN_ZEROS = 4'd11;
   localparam logic [2:0] RTC_EOLS      = 3'd6;
   localparam logic [3:0] DISC_LEN      = 4'd10;
   localparam logic [7:0] TIMEOUT_RESET = 8'd30;
   // widest of timer and timeout register, for the compare
   localparam int CMP_W = (TIMER_BITS > 8) ? TIMER_BITS : 8;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   // characters of the disconnect string in match order
   function automatic logic [7:0] disc_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h44; // D
         4'd1:    ch = 8'h49; // I
         4'd2:    ch = 8'h53; // S
         4'd3:    ch = 8'h43; // C
         4'd4:    ch = 8'h4F; // O
         4'd5:    ch = 8'h4E; // N
         4'd6:    ch = 8'h4E; // N
         4'd7:    ch = 8'h45; // E
         4'd8:    ch = 8'h43; // C
         4'd9:    ch = 8'h54; // T
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // zeros before the first one bit, from bit 0 upward
   function automatic logic [3:0] lead_zeros(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd8;
      for (int i = 7; i >= 0; i--) begin
         if (b[i]) begin
            n = 4'(i);
         end
      end
      return n;
   endfunction

   // zeros after the last one bit, from bit 7 downward
   function automatic logic [3:0] trail_zeros(input logic [7:0] b);
      logic [3:0] n;
      n = 4'd8;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            n = 4'(7 - i);
         end
      end
      return n;
   endfunction

   // configuration
   logic [7:0] timeout_ff;

   // scanner state
   logic [3:0]            zero_run_ff, zero_run_in;
   logic                  eol_pending_ff, eol_pending_in;
   logic [2:0]            eol_run_ff, eol_run_in;
   logic [3:0]            match_pos_ff, match_pos_in;
   logic [15:0]           pages_ff, pages_in;
   logic                  carrier_up_ff, carrier_up_in;
   logic [TIMER_BITS-1:0] ticks_ff, ticks_in;
   logic                  halted_ff, halted_in;
   fepd_pkg::stop_cause_type cause_ff, cause_in;

   // output register
   logic                      rsp_valid_ff;
   fepd_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic       req_accept;
   logic [7:0] byte_val;
   logic [3:0] lead;
   logic [3:0] trail;
   logic [4:0] run_sum;
   logic       eol;
   logic       pend;
   logic       pending_now;
   logic [2:0] eol_run_inc;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign byte_val = req_payload.data_byte;
   assign lead     = lead_zeros(byte_val);
   assign trail    = trail_zeros(byte_val);
   assign run_sum  = {1'b0, zero_run_ff} + {1'b0, lead};

   always_comb begin
      zero_run_in    = zero_run_ff;
      eol_pending_in = eol_pending_ff;
      eol_run_in     = eol_run_ff;
      match_pos_in   = match_pos_ff;
      pages_in       = pages_ff;
      carrier_up_in  = carrier_up_ff;
      ticks_in       = ticks_ff;
      halted_in      = halted_ff;
      cause_in       = cause_ff;
      eol            = 1'b0;
      pend           = 1'b0;
      pending_now    = 1'b0;
      eol_run_inc    = eol_run_ff + 3'd1;

      if (!halted_ff) begin
         if (req_payload.req_type == fepd_pkg::ITEM_DATA) begin
            // naive string match, a mismatch restarts without retrying this byte
            if (match_pos_ff < DISC_LEN && disc_char(match_pos_ff) == byte_val) begin
               match_pos_in = match_pos_ff + 4'd1;
               if (match_pos_ff + 4'd1 >= DISC_LEN) begin
                  halted_in = 1'b1;
                  cause_in  = fepd_pkg::STOP_DISCONNECT;
               end
            end else begin
               match_pos_in = 4'd0;
            end

            // zero run tracking, long run stays pending until a one bit
            if (eol_pending_ff || run_sum >= {1'b0, EOL_MIN_ZEROS}) begin
               pending_now = 1'b1;
            end else if (byte_val != 8'h00) begin
               zero_run_in = trail;
               eol_run_in  = 3'd0;
            end else begin
               zero_run_in = zero_run_ff + 4'd8;
            end
            eol_pending_in = pending_now;

            if (pending_now && byte_val != 8'h00) begin
               eol_pending_in = 1'b0;
               eol            = 1'b1;
               zero_run_in    = trail;
               eol_run_in     = eol_run_inc;
               if (eol_run_inc >= RTC_EOLS) begin
                  pend       = 1'b1;
                  pages_in   = pages_ff + 16'd1;
                  eol_run_in = 3'd0;
               end
            end
         end else begin
            // carrier tick
            if (req_payload.carrier_present) begin
               carrier_up_in = 1'b1;
               ticks_in      = '0;
            end else if (carrier_up_ff) begin
               carrier_up_in = 1'b0;
               ticks_in      = '0;
            end else if (CMP_W'(ticks_ff) >= CMP_W'(timeout_ff)) begin
               halted_in = 1'b1;
               cause_in  = fepd_pkg::STOP_CARRIER;
            end else if (ticks_ff != TIMER_MAX) begin
               ticks_in = ticks_ff + 1'b1;
            end
         end
      end

      rsp_payload_in.page_count = pages_in;
      rsp_payload_in.eol_seen   = eol;
      rsp_payload_in.page_end   = pend;
      rsp_payload_in.stopped    = halted_in;
      rsp_payload_in.stop_cause = cause_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= TIMEOUT_RESET;
         zero_run_ff    <= 4'd0;
         eol_pending_ff <= 1'b0;
         eol_run_ff     <= 3'd0;
         match_pos_ff   <= 4'd0;
         pages_ff       <= 16'd1;
         carrier_up_ff  <= 1'b1;
         ticks_ff       <= '0;
         halted_ff      <= 1'b0;
         cause_ff       <= fepd_pkg::STOP_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
         if (req_accept) begin
            zero_run_ff    <= zero_run_in;
            eol_pending_ff <= eol_pending_in;
            eol_run_ff     <= eol_run_in;
            match_pos_ff   <= match_pos_in;
            pages_ff       <= pages_in;
            carrier_up_ff  <= carrier_up_in;
            ticks_ff       <= ticks_in;
            halted_ff      <= halted_in;
            cause_ff       <= cause_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

>>> hdl/fepd_checker.sv
// port-level checks for the fax eol / rtc page detector, with its bind
// depends on fepd_pkg and fax_eol_rtc_page_detector
module fepd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input fepd_pkg::rsp_payload_type rsp_payload
);

   // a stopped response has been delivered since reset
   logic seen_stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_stop_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_payload.stopped) begin
         seen_stop_ff <= 1'b1;
      end
   end

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // every accepted request gives a response on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after accepted request");

   // page end only together with an end-of-line
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.page_end |-> rsp_payload.eol_seen)
      else $error("page end without end-of-line");

   // stop is sticky, carries a cause and shows no end-of-line
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_stop_ff |-> rsp_payload.stopped
         && rsp_payload.stop_cause != fepd_pkg::STOP_NONE
         && !rsp_payload.eol_seen)
      else $error("stopped state lost or stop cause missing");

endmodule

bind fax_eol_rtc_page_detector fepd_checker u_fepd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
